// ===== hdl/frt_pkg.sv =====
// Shared types and result codes for the fragment reassembly table.
package frt_pkg;

	typedef enum logic [1:0] {
		KIND_STORED = 2'd0,
		KIND_FULL   = 2'd1,
		KIND_BAD    = 2'd2,
		KIND_DATA   = 2'd3
	} kind_t;

	localparam int unsigned WORDS_PER_FRAG = 3;

	// Byte-keep mask for one 64-bit payload word starting at byte `first`.
	function automatic logic [63:0] keep_mask(input logic [4:0] len, input logic [4:0] first);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (len > first + 5'(b))
				m[b*8 +: 8] = 8'hFF;
		end
		return m;
	endfunction

endpackage

// ===== hdl/fragment_reassembly_table_top.sv =====
// Top level of the fragment reassembly table: slot search, storage sequencer and output.
// Each fragment transaction is taken when in_stall is low and handled alone. The slot search
// visits one slot per cycle with one shared id comparator and stops early on a match. Then
// three payload words go into the word memory one per cycle. The time until the next fragment
// can be accepted is shorter when a match is found early, and longer while a status result
// waits on out_stall. When the last missing fragment of a message arrives, the stored
// fragments are read back in order. Each takes three word reads over the single read port and
// then an emit step, which waits while out_stall holds the output register. The last data
// result carries last_of_run. A rejected fragment (bad number or total, table full) gives one
// status result. Slot state lives in flip-flops cleared by reset. The payload memory needs no
// clearing, since only fragments written for the current message are ever read.
module fragment_reassembly_table_top #(
	parameter int SLOTS = 8,
	parameter int MAX_FRAGS = 16,
	parameter int PAYLOAD_BYTES = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [15:0]  message_id,
	input  logic [4:0]   fragment_number,
	input  logic [4:0]   fragment_total,
	input  logic [4:0]   payload_length,
	input  logic [63:0]  payload_low,
	input  logic [63:0]  payload_middle,
	input  logic [31:0]  payload_high,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [1:0]   result_kind,
	output logic [15:0]  out_message_id,
	output logic [4:0]   out_fragment_number,
	output logic [4:0]   out_length,
	output logic [63:0]  out_low,
	output logic [63:0]  out_middle,
	output logic [31:0]  out_high,
	output logic         last_of_run
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FW = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
	localparam int WAW = $clog2(SLOTS*MAX_FRAGS*3);
	localparam int LAW = $clog2(SLOTS*MAX_FRAGS);
	localparam logic [4:0] PBYTES = 5'(PAYLOAD_BYTES);
	localparam logic [5:0] MAXF = 6'(MAX_FRAGS);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SEARCH, ST_DECIDE, ST_WRITE, ST_CHECK, ST_READ, ST_EMIT, ST_STATUS
	} state_t;

	state_t state_q;

	// slot table
	logic [SLOTS-1:0]     busy_q;
	logic [15:0]          sid_q   [SLOTS];
	logic [4:0]           stot_q  [SLOTS];
	logic [MAX_FRAGS-1:0] smap_q  [SLOTS];

	// captured transaction
	logic [15:0] id_q;
	logic [4:0]  num_q, tot_q, len_q;
	logic [63:0] w0_q, w1_q;
	logic [31:0] w2_q;

	logic [SW:0] scan_q;
	logic        match_q, free_q;
	logic [SW-1:0] mslot_q, fslot_q, slot_q;
	logic [4:0]  total_q;
	logic [1:0]  widx_q;
	logic [4:0]  fidx_q;
	logic [2:0]  rph_q;
	logic [63:0] r0_q, r1_q;
	frt_pkg::kind_t kind_q;

	// memory hookup
	logic            wr_en, len_wr_en;
	logic [WAW-1:0]  wr_addr, rd_addr;
	logic [LAW-1:0]  len_addr, len_rd_addr;
	logic [63:0]     wr_data, rd_data;
	logic [4:0]      len_rd_data;
	logic [LAW-1:0]  wbase, rbase;
	logic [FW-1:0]   fsel;
	logic [63:0]     hmask;

	assign fsel    = FW'(num_q - 5'd1);
	assign wbase   = LAW'(slot_q) * LAW'(MAX_FRAGS) + LAW'(fsel);
	assign rbase   = LAW'(slot_q) * LAW'(MAX_FRAGS) + LAW'(fidx_q);
	assign wr_en   = (state_q == ST_WRITE);
	assign len_wr_en = wr_en && (widx_q == 2'd0);
	assign len_addr  = wbase;
	assign wr_addr   = WAW'(wbase) * WAW'(3) + WAW'(widx_q);
	assign rd_addr   = WAW'(rbase) * WAW'(3) + WAW'((rph_q > 3'd2) ? 3'd2 : rph_q);
	assign len_rd_addr = rbase;
	assign hmask     = frt_pkg::keep_mask(len_q, 5'd16);

	always_comb begin
		case (widx_q)
			2'd0:    wr_data = w0_q & frt_pkg::keep_mask(len_q, 5'd0);
			2'd1:    wr_data = w1_q & frt_pkg::keep_mask(len_q, 5'd8);
			default: wr_data = {32'd0, w2_q & hmask[31:0]};
		endcase
	end

	frt_store #(.SLOTS(SLOTS), .MAX_FRAGS(MAX_FRAGS)) u_store (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.len_wr_en(len_wr_en), .len_addr(len_addr), .len_data(len_q),
		.rd_addr(rd_addr), .len_rd_addr(len_rd_addr),
		.rd_data(rd_data), .len_rd_data(len_rd_data)
	);

	assign in_stall = (state_q != ST_IDLE);

	logic [SW-1:0] sc;
	logic [5:0]    tot_chk;
	logic          bad;
	logic          load_out;
	logic [MAX_FRAGS-1:0] newmap, fullmask;
	assign sc = scan_q[SW-1:0];
	assign tot_chk = {1'b0, match_q ? stot_q[mslot_q] : tot_q};
	assign bad = (tot_chk == 6'd0) || (tot_chk > MAXF) || (num_q == 5'd0) ||
		({1'b0, num_q} > tot_chk);
	assign newmap = smap_q[slot_q] | (MAX_FRAGS'(1) << fsel);
	assign fullmask = MAX_FRAGS'(({{MAX_FRAGS{1'b0}}, 1'b1} << total_q) - 1'b1);
	// a new result goes into the output register this cycle
	assign load_out = ((state_q == ST_STATUS) || (state_q == ST_EMIT)) &&
		(!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			busy_q    <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				sid_q[i]  <= '0;
				stot_q[i] <= '0;
				smap_q[i] <= '0;
			end
		end else begin
			if (out_valid && !out_stall && !load_out)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						id_q <= message_id; num_q <= fragment_number;
						tot_q <= fragment_total;
						len_q <= (payload_length > PBYTES) ? PBYTES : payload_length;
						w0_q <= payload_low; w1_q <= payload_middle; w2_q <= payload_high;
						scan_q <= '0; match_q <= 1'b0; free_q <= 1'b0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					// one slot per cycle; the first match wins, the first free slot is kept
					if (busy_q[sc] && sid_q[sc] == id_q) begin
						match_q <= 1'b1; mslot_q <= sc; state_q <= ST_DECIDE;
					end else begin
						if (!busy_q[sc] && !free_q) begin
							free_q <= 1'b1; fslot_q <= sc;
						end
						if (scan_q == (SW+1)'(SLOTS - 1))
							state_q <= ST_DECIDE;
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_DECIDE: begin
					if (bad || (!match_q && !free_q)) begin
						kind_q <= bad ? frt_pkg::KIND_BAD : frt_pkg::KIND_FULL;
						state_q <= ST_STATUS;
					end else begin
						slot_q <= match_q ? mslot_q : fslot_q;
						total_q <= tot_chk[4:0];
						if (!match_q) begin
							busy_q[fslot_q] <= 1'b1;
							sid_q[fslot_q]  <= id_q;
							stot_q[fslot_q] <= tot_q;
							smap_q[fslot_q] <= '0;
						end
						widx_q <= '0;
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					widx_q <= widx_q + 2'd1;
					if (widx_q == 2'd2) begin
						smap_q[slot_q] <= newmap;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if ((smap_q[slot_q] & fullmask) == fullmask) begin
						fidx_q <= '0; rph_q <= '0;
						state_q <= ST_READ;
					end else begin
						kind_q <= frt_pkg::KIND_STORED;
						state_q <= ST_STATUS;
					end
				end
				ST_STATUS: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						result_kind <= kind_q;
						out_message_id <= id_q; out_fragment_number <= num_q;
						out_length <= '0; out_low <= '0; out_middle <= '0; out_high <= '0;
						last_of_run <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					// three word reads; data returns in the cycle after each address,
					// and the third word stays on rd_data through the emit cycle
					rph_q <= rph_q + 3'd1;
					if (rph_q == 3'd1) r0_q <= rd_data;
					if (rph_q == 3'd2) r1_q <= rd_data;
					if (rph_q == 3'd3) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						result_kind <= frt_pkg::KIND_DATA;
						out_message_id <= id_q;
						out_fragment_number <= fidx_q + 5'd1;
						out_length <= len_rd_data;
						out_low <= r0_q; out_middle <= r1_q; out_high <= rd_data[31:0];
						last_of_run <= (fidx_q + 5'd1 == total_q);
						rph_q <= '0;
						if (fidx_q + 5'd1 == total_q) begin
							busy_q[slot_q] <= 1'b0;
							sid_q[slot_q]  <= '0;
							stot_q[slot_q] <= '0;
							smap_q[slot_q] <= '0;
							state_q <= ST_IDLE;
						end else begin
							fidx_q <= fidx_q + 5'd1;
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind != frt_pkg::KIND_DATA) |-> (last_of_run && out_length == 5'd0))
		else $error("status result malformed");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_length <= PBYTES))
		else $error("length above payload size");
`endif
endmodule

// ===== hdl/frt_store.sv =====
// Payload and length storage for every slot and fragment position.
module frt_store #(
	parameter int SLOTS = 8,
	parameter int MAX_FRAGS = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [$clog2(SLOTS*MAX_FRAGS*3)-1:0]   wr_addr,
	input  logic [63:0]                            wr_data,
	input  logic                                   len_wr_en,
	input  logic [$clog2(SLOTS*MAX_FRAGS)-1:0]     len_addr,
	input  logic [4:0]                             len_data,
	input  logic [$clog2(SLOTS*MAX_FRAGS*3)-1:0]   rd_addr,
	input  logic [$clog2(SLOTS*MAX_FRAGS)-1:0]     len_rd_addr,
	output logic [63:0]                            rd_data,
	output logic [4:0]                             len_rd_data
);
	localparam int WDEPTH = SLOTS * MAX_FRAGS * 3;
	localparam int LDEPTH = SLOTS * MAX_FRAGS;

	logic [63:0] words_q [WDEPTH];
	logic [4:0]  lens_q  [LDEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			words_q[wr_addr] <= wr_data;
		rd_data <= words_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (len_wr_en)
			lens_q[len_addr] <= len_data;
		len_rd_data <= lens_q[len_rd_addr];
	end
endmodule

// ===== test/tb.sv =====
// Testbench for the fragment reassembly table: directed and random fragments, scoreboard check.
module tb;
	localparam int SLOTS = 8;
	localparam int MAX_FRAGS = 16;
	localparam int PAYLOAD_BYTES = 20;

	// One expected or observed result transaction.
	typedef struct {
		frt_pkg::kind_t kind;
		logic [15:0] id;
		logic [4:0]  num;
		logic [4:0]  len;
		logic [63:0] lo;
		logic [63:0] mid;
		logic [31:0] hi;
		logic        last;
	} frag_result_t;

	// Scoreboard: keeps its own copy of the slot table and the queue of pending results.
	class reassembly_scoreboard;
		bit          busy[SLOTS];
		logic [15:0] slot_id[SLOTS];
		logic [4:0]  slot_total[SLOTS];
		logic [15:0] rx_map[SLOTS];
		logic [63:0] words[SLOTS][MAX_FRAGS][3];
		logic [4:0]  lens[SLOTS][MAX_FRAGS];
		frag_result_t pending[$];
		int errors;
		int results_seen;
		int completions;

		function automatic logic [63:0] trim(logic [63:0] w, int len, int first);
			logic [63:0] m;
			m = '0;
			for (int b = 0; b < 8; b++)
				if (len > first + b) m[b*8 +: 8] = 8'hFF;
			return w & m;
		endfunction

		function void push_status(frt_pkg::kind_t k, logic [15:0] id, logic [4:0] num);
			frag_result_t r;
			r.kind = k; r.id = id; r.num = num; r.len = '0;
			r.lo = '0; r.mid = '0; r.hi = '0; r.last = 1'b1;
			pending.push_back(r);
		endfunction

		// Note an accepted fragment and queue the results it causes.
		function void note_fragment(logic [15:0] id, logic [4:0] num, logic [4:0] tot,
				logic [4:0] plen, logic [63:0] lo, logic [63:0] mid, logic [31:0] hi);
			int hit, vacant, s, total, len;
			frag_result_t r;
			hit = -1; vacant = -1;
			for (int i = 0; i < SLOTS; i++) begin
				if (busy[i] && slot_id[i] == id) begin
					hit = i;
					break;
				end
				if (!busy[i] && vacant < 0) vacant = i;
			end
			total = (hit >= 0) ? slot_total[hit] : tot;
			if (total == 0 || total > MAX_FRAGS || num == 0 || num > total) begin
				push_status(frt_pkg::KIND_BAD, id, num);
				return;
			end
			if (hit < 0 && vacant < 0) begin
				push_status(frt_pkg::KIND_FULL, id, num);
				return;
			end
			if (hit >= 0) s = hit;
			else begin
				s = vacant;
				busy[s] = 1; slot_id[s] = id; slot_total[s] = tot; rx_map[s] = '0;
			end
			len = (plen > PAYLOAD_BYTES) ? PAYLOAD_BYTES : plen;
			lens[s][num-1] = 5'(len);
			words[s][num-1][0] = trim(lo, len, 0);
			words[s][num-1][1] = trim(mid, len, 8);
			words[s][num-1][2] = trim({32'd0, hi}, len, 16);
			rx_map[s][num-1] = 1'b1;
			if ((rx_map[s] & ((17'd1 << total) - 1)) != ((17'd1 << total) - 1)) begin
				push_status(frt_pkg::KIND_STORED, id, num);
				return;
			end
			for (int f = 0; f < total; f++) begin
				r.kind = frt_pkg::KIND_DATA; r.id = id; r.num = 5'(f + 1); r.len = lens[s][f];
				r.lo = words[s][f][0]; r.mid = words[s][f][1]; r.hi = words[s][f][2][31:0];
				r.last = (f + 1 == total);
				pending.push_back(r);
			end
			completions++;
			busy[s] = 0; slot_id[s] = '0; slot_total[s] = '0; rx_map[s] = '0;
		endfunction

		// Compare one observed result with the oldest expectation.
		function void check_result(frag_result_t got);
			frag_result_t exp_r;
			results_seen++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result kind %0d id %h", $time, got.kind, got.id);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.kind != exp_r.kind) begin
				$display("%0t: kind exp %0d got %0d", $time, exp_r.kind, got.kind);
				errors++;
			end
			if (got.id != exp_r.id) begin
				$display("%0t: id exp %h got %h", $time, exp_r.id, got.id);
				errors++;
			end
			if (got.num != exp_r.num) begin
				$display("%0t: number exp %0d got %0d", $time, exp_r.num, got.num);
				errors++;
			end
			if (got.len != exp_r.len) begin
				$display("%0t: length exp %0d got %0d", $time, exp_r.len, got.len);
				errors++;
			end
			if (got.lo != exp_r.lo) begin
				$display("%0t: low exp %h got %h", $time, exp_r.lo, got.lo);
				errors++;
			end
			if (got.mid != exp_r.mid) begin
				$display("%0t: middle exp %h got %h", $time, exp_r.mid, got.mid);
				errors++;
			end
			if (got.hi != exp_r.hi) begin
				$display("%0t: high exp %h got %h", $time, exp_r.hi, got.hi);
				errors++;
			end
			if (got.last != exp_r.last) begin
				$display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         in_valid;
	logic         in_stall;
	logic [15:0]  message_id;
	logic [4:0]   fragment_number;
	logic [4:0]   fragment_total;
	logic [4:0]   payload_length;
	logic [63:0]  payload_low;
	logic [63:0]  payload_middle;
	logic [31:0]  payload_high;
	logic         out_valid;
	logic         out_stall;
	logic [1:0]   result_kind;
	logic [15:0]  out_message_id;
	logic [4:0]   out_fragment_number;
	logic [4:0]   out_length;
	logic [63:0]  out_low;
	logic [63:0]  out_middle;
	logic [31:0]  out_high;
	logic         last_of_run;

	reassembly_scoreboard board;
	int sent;
	bit quiet_gaps;   // when set, both sides run without idling

	fragment_reassembly_table_top #(
		.SLOTS(SLOTS), .MAX_FRAGS(MAX_FRAGS), .PAYLOAD_BYTES(PAYLOAD_BYTES)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.message_id(message_id), .fragment_number(fragment_number),
		.fragment_total(fragment_total), .payload_length(payload_length),
		.payload_low(payload_low), .payload_middle(payload_middle),
		.payload_high(payload_high),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_kind(result_kind), .out_message_id(out_message_id),
		.out_fragment_number(out_fragment_number), .out_length(out_length),
		.out_low(out_low), .out_middle(out_middle), .out_high(out_high),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Hard limit: a run that hangs is stopped here and reported as having errors.
	initial begin
		#2000000;
		$display("tb: done, errors");
		$finish;
	end

	// Sink: draw a stall length per result, hold stall high that long, then take one
	// transaction and check it at the rising edge.
	initial begin
		int wait_cycles;
		frag_result_t got;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			wait_cycles = quiet_gaps ? 0 : $urandom_range(0, 8);
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			out_stall <= 1'b0;
			// advance until a result transaction is accepted
			do @(posedge clk); while (!out_valid);
			got.kind = frt_pkg::kind_t'(result_kind); got.id = out_message_id;
			got.num = out_fragment_number; got.len = out_length;
			got.lo = out_low; got.mid = out_middle; got.hi = out_high;
			got.last = last_of_run;
			board.check_result(got);
		end
	end

	// Drive one fragment transaction: idle a random gap, raise valid, hold until accepted.
	task automatic send_fragment(logic [15:0] id, logic [4:0] num, logic [4:0] tot,
			logic [4:0] plen, logic [63:0] lo, logic [63:0] mid, logic [31:0] hi);
		int gap;
		gap = quiet_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		message_id <= id; fragment_number <= num; fragment_total <= tot;
		payload_length <= plen; payload_low <= lo; payload_middle <= mid;
		payload_high <= hi;
		do @(posedge clk); while (in_stall);
		board.note_fragment(id, num, tot, plen, lo, mid, hi);
		sent++;
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_random_payload(logic [15:0] id, logic [4:0] num, logic [4:0] tot,
			logic [4:0] plen);
		send_fragment(id, num, tot, plen, rand64(), rand64(), $urandom);
	endtask

	// Send a whole message of tot fragments in shuffled order, with an optional duplicate.
	task automatic send_message(logic [15:0] id, int tot);
		int order[$];
		int j, t;
		for (int i = 1; i <= tot; i++) order.push_back(i);
		for (int i = tot - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i]; order[i] = order[j]; order[j] = t;
		end
		// a duplicate ahead of the last fragment exercises payload overwrite
		if (tot > 1 && $urandom_range(0, 3) == 0)
			order.insert(tot - 1, order[0]);
		foreach (order[k])
			send_random_payload(id, 5'(order[k]), 5'((k == 0) ? tot : $urandom_range(0, 31)),
				5'($urandom_range(0, 31)));
	endtask

	// Drop valid and wait until every expected result has come.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (SLOTS + 40) @(negedge clk);
	endtask

	initial begin
		int choice, tot;
		logic [15:0] id;
		board = new();
		sent = 0;
		quiet_gaps = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		message_id = '0; fragment_number = '0; fragment_total = '0;
		payload_length = '0; payload_low = '0; payload_middle = '0; payload_high = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: bad numbers and totals, all-ones and all-zero payloads, length extremes.
		send_fragment(16'h0000, 0, 4, 20, '1, '1, '1);          // number zero
		send_fragment(16'hFFFF, 1, 0, 20, '1, '1, '1);          // total zero
		send_fragment(16'h1234, 1, 17, 20, '1, '1, '1);         // total above limit
		send_fragment(16'h1234, 31, 31, 31, '1, '1, '1);        // both maximal
		send_fragment(16'h00AA, 3, 2, 5, '1, '1, '1);           // number above total
		send_fragment(16'hFFFF, 1, 1, 31, '1, '1, '1);          // single fragment, overlong
		send_fragment(16'h0000, 1, 1, 0, '1, '1, '1);           // zero length
		send_fragment(16'h0001, 1, 1, 20, '0, '0, '0);
		send_fragment(16'h0002, 1, 1, 13, '1, '1, '1);          // partial middle word
		// keeps the recorded total: second fragment carries a different total
		send_fragment(16'h0100, 2, 3, 7, rand64(), rand64(), $urandom);
		send_fragment(16'h0100, 2, 9, 19, rand64(), rand64(), $urandom); // duplicate
		send_fragment(16'h0100, 4, 9, 4, rand64(), rand64(), $urandom);  // above recorded
		send_fragment(16'h0100, 1, 0, 8, rand64(), rand64(), $urandom);
		send_fragment(16'h0100, 3, 0, 16, rand64(), rand64(), $urandom); // completes
		// fill every slot, then overflow, then complete one and reuse it
		for (int i = 0; i < SLOTS; i++)
			send_random_payload(16'h0200 + 16'(i), 1, 2, 5'($urandom_range(0, 20)));
		send_random_payload(16'h0300, 1, 2, 20);                         // table full
		send_random_payload(16'h0203, 2, 5, 20);
		send_random_payload(16'h0300, 1, 1, 20);
		drain();

		// pause until every result has come, then clear the leftover slots
		for (int i = 0; i < SLOTS; i++)
			if (i != 3)
				send_random_payload(16'h0200 + 16'(i), 2, 0, 5'($urandom_range(0, 31)));
		drain();

		// Random: mostly whole messages with random content, the rest noise.
		while (sent < 310) begin
			quiet_gaps = ($urandom_range(0, 9) == 0);
			choice = $urandom_range(0, 9);
			id = (choice < 8) ? 16'($urandom_range(0, 40)) : 16'($urandom);
			if (choice < 7) begin
				tot = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16)
					: $urandom_range(1, 4);
				send_message(id, tot);
			end else begin
				send_random_payload(id, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
					5'($urandom_range(0, 31)));
			end
		end
		quiet_gaps = 0;
		drain();

		$display("tb: %0d fragments sent, %0d results checked, %0d messages reassembled",
			sent, board.results_seen, board.completions);
		$display("tb: covered bad fragments, full table, duplicates and overlong payloads");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule

// ===== fragment_reassembly_table_top.f =====
hdl/frt_pkg.sv
hdl/frt_store.sv
hdl/fragment_reassembly_table_top.sv
test/tb.sv
